[rtl/core/irpw_pkg.sv]
// Shared types and constants for the pulse-width IR transmitter.
`timescale 1ns / 1ps

package irpw_pkg;

    localparam int CODE_W     = 12;                         // code_word field width
    localparam int CODE_BITS  = 12;                         // bits sent per frame
    localparam int BIT_IDX_W  = $clog2(CODE_BITS + 1);
    localparam int TICK_W     = 20;
    localparam int REP_W      = 3;
    localparam int DIV_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 3'd6;

    // request kinds carried on tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SEND = 1'b1;

    // register reset values
    localparam logic [TICK_W-1:0] HEADER_RST  = 20'd18952;
    localparam logic [TICK_W-1:0] SPACE_RST   = 20'd4800;
    localparam logic [TICK_W-1:0] ONE_RST     = 20'd9600;
    localparam logic [TICK_W-1:0] ZERO_RST    = 20'd4800;
    localparam logic [TICK_W-1:0] GAP_RST     = 20'd356768;
    localparam logic [REP_W-1:0]  REPEAT_RST  = 3'd2;
    localparam logic [DIV_W-1:0]  CARRIER_RST = 8'd104;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_HEADER   = 6'b000010,
        PH_HSPACE   = 6'b000100,
        PH_BITMARK  = 6'b001000,
        PH_BITSPACE = 6'b010000,
        PH_GAP      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] header_ticks;
        logic [TICK_W-1:0] space_ticks;
        logic [TICK_W-1:0] one_ticks;
        logic [TICK_W-1:0] zero_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [REP_W-1:0]  repeat_count;
        logic [DIV_W-1:0]  carrier_div;
    } cfg_t;

    // sequencer status: current-state flags and the flags after this request
    typedef struct packed {
        logic idle;         // phase register is idle
        logic frames_live;  // frames still owed
        logic mark_next;
        logic busy_next;
        logic done_next;
    } seq_stat_t;

endpackage

[rtl/core/irpw_carrier.sv]
// Free-running carrier divider, stepped once per tick request.
`timescale 1ns / 1ps

module irpw_carrier (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic [irpw_pkg::DIV_W-1:0] carrier_div,
    output logic                      level_next
);

    logic [irpw_pkg::DIV_W-1:0] count_reg;
    logic [irpw_pkg::DIV_W-1:0] count_next;
    logic                       level_reg;
    logic                       lvl_next;

    always_comb
    begin
        count_next = count_reg;
        lvl_next   = level_reg;
        if (tick)
        begin
            if (count_reg >= carrier_div)
            begin
                count_next = '0;
                lvl_next   = ~level_reg;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    assign level_next = lvl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= lvl_next;
        end
    end

endmodule

[rtl/core/irpw_sequencer.sv]
// Frame sequencer: header, bit marks and spaces, repeats and gaps.
`timescale 1ns / 1ps

module irpw_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick,
    input  logic                            send,
    input  logic [irpw_pkg::CODE_W-1:0]     code,
    input  irpw_pkg::cfg_t                  cfg,
    output irpw_pkg::seq_stat_t             stat
);

    irpw_pkg::phase_t                   phase_reg, phase_next;
    logic [irpw_pkg::BIT_IDX_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [irpw_pkg::CODE_BITS-1:0]     shift_reg, shift_next;
    logic [irpw_pkg::CODE_BITS-1:0]     latched_reg, latched_next;
    logic [irpw_pkg::TICK_W-1:0]        dur_reg, dur_next;
    logic [irpw_pkg::REP_W-1:0]         frames_reg, frames_next;
    logic                               done;
    logic [irpw_pkg::CODE_BITS-1:0]     shifted;
    logic [irpw_pkg::BIT_IDX_W-1:0]     bit_idx_inc;
    logic [irpw_pkg::CODE_BITS-1:0]     word_in;

    assign shifted     = shift_reg << 1;
    assign bit_idx_inc = bit_idx_reg + 1'b1;
    assign word_in     = irpw_pkg::CODE_BITS'(code);

    always_comb
    begin
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        latched_next = latched_reg;
        dur_next     = dur_reg;
        frames_next  = frames_reg;
        done         = 1'b0;

        if (send && phase_reg == irpw_pkg::PH_IDLE)
        begin
            latched_next = word_in;
            frames_next  = (cfg.repeat_count == '0) ? irpw_pkg::REP_W'(1) : cfg.repeat_count;
            shift_next   = word_in;
            bit_idx_next = '0;
            phase_next   = irpw_pkg::PH_HEADER;
            dur_next     = cfg.header_ticks;
        end
        else if (tick && phase_reg != irpw_pkg::PH_IDLE)
        begin
            if (dur_reg > irpw_pkg::TICK_W'(1))
            begin
                dur_next = dur_reg - 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    irpw_pkg::PH_HEADER:
                    begin
                        phase_next = irpw_pkg::PH_HSPACE;
                        dur_next   = cfg.space_ticks;
                    end
                    irpw_pkg::PH_HSPACE:
                    begin
                        phase_next = irpw_pkg::PH_BITMARK;
                        dur_next   = shift_reg[irpw_pkg::CODE_BITS-1] ?
                                     cfg.one_ticks : cfg.zero_ticks;
                    end
                    irpw_pkg::PH_BITMARK:
                    begin
                        phase_next = irpw_pkg::PH_BITSPACE;
                        dur_next   = cfg.space_ticks;
                    end
                    irpw_pkg::PH_BITSPACE:
                    begin
                        shift_next   = shifted;
                        bit_idx_next = bit_idx_inc;
                        if (bit_idx_inc < irpw_pkg::BIT_IDX_W'(irpw_pkg::CODE_BITS))
                        begin
                            phase_next = irpw_pkg::PH_BITMARK;
                            dur_next   = shifted[irpw_pkg::CODE_BITS-1] ?
                                         cfg.one_ticks : cfg.zero_ticks;
                        end
                        else if (frames_reg > irpw_pkg::REP_W'(1))
                        begin
                            frames_next = frames_reg - 1'b1;
                            if (cfg.gap_ticks == '0)
                            begin
                                shift_next   = latched_reg;
                                bit_idx_next = '0;
                                phase_next   = irpw_pkg::PH_HEADER;
                                dur_next     = cfg.header_ticks;
                            end
                            else
                            begin
                                phase_next = irpw_pkg::PH_GAP;
                                dur_next   = cfg.gap_ticks;
                            end
                        end
                        else
                        begin
                            frames_next  = '0;
                            phase_next   = irpw_pkg::PH_IDLE;
                            dur_next     = '0;
                            bit_idx_next = '0;
                            done         = 1'b1;
                        end
                    end
                    irpw_pkg::PH_GAP:
                    begin
                        shift_next   = latched_reg;
                        bit_idx_next = '0;
                        phase_next   = irpw_pkg::PH_HEADER;
                        dur_next     = cfg.header_ticks;
                    end
                    default:
                    begin
                        phase_next = irpw_pkg::PH_IDLE;
                        dur_next   = '0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        stat.idle        = (phase_reg == irpw_pkg::PH_IDLE);
        stat.frames_live = (frames_reg != '0);
        stat.mark_next   = (phase_next == irpw_pkg::PH_HEADER) ||
                           (phase_next == irpw_pkg::PH_BITMARK);
        stat.busy_next   = (phase_next != irpw_pkg::PH_IDLE);
        stat.done_next   = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= irpw_pkg::PH_IDLE;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            latched_reg <= '0;
            dur_reg     <= '0;
            frames_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            latched_reg <= latched_next;
            dur_reg     <= dur_next;
            frames_reg  <= frames_next;
        end
    end

endmodule

[rtl/core/ir_pulse_width_transmitter.sv]
// A request is held in the input register, and its result then waits in the result register.
// Throughput: one request per cycle while results are taken; each yields exactly one result.
// The rate is set by the single pass from the input register through the sequencer and
// carrier divider into the result register.
// Reset (rst_n low, asynchronous): idle, carrier low, config at defaults, pipeline empty.
`timescale 1ns / 1ps

module ir_pulse_width_transmitter (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [irpw_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [11:0] code_word, rest zero
    input  logic                               s_axis_tuser,  // [0] func
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [irpw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [0] ir_out, [1] mark_active,
                                                               // [2] busy_res, [3] done_res
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [irpw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irpw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // config registers
    irpw_pkg::cfg_t cfg_reg;
    irpw_pkg::cfg_t cfg_next;

    // input stage
    logic                            in_valid_reg, in_valid_next;
    logic                            in_func_reg;
    logic [irpw_pkg::CODE_W-1:0]     in_code_reg;

    // result stage
    logic                            out_valid_reg, out_valid_next;
    logic [3:0]                      out_bits_reg;

    logic                            adv;       // input stage moves into the result stage
    logic                            tick;
    logic                            send;
    logic                            level_next;
    irpw_pkg::seq_stat_t             stat;

    // Config port never stalls; writes take effect at once, so send them while idle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                irpw_pkg::REG_HEADER:  cfg_next.header_ticks = cfg_data;
                irpw_pkg::REG_SPACE:   cfg_next.space_ticks  = cfg_data;
                irpw_pkg::REG_ONE:     cfg_next.one_ticks    = cfg_data;
                irpw_pkg::REG_ZERO:    cfg_next.zero_ticks   = cfg_data;
                irpw_pkg::REG_GAP:     cfg_next.gap_ticks    = cfg_data;
                irpw_pkg::REG_REPEAT:  cfg_next.repeat_count = cfg_data[irpw_pkg::REP_W-1:0];
                irpw_pkg::REG_CARRIER: cfg_next.carrier_div  = cfg_data[irpw_pkg::DIV_W-1:0];
                default:               cfg_next = cfg_reg;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_ticks <= irpw_pkg::HEADER_RST;
            cfg_reg.space_ticks  <= irpw_pkg::SPACE_RST;
            cfg_reg.one_ticks    <= irpw_pkg::ONE_RST;
            cfg_reg.zero_ticks   <= irpw_pkg::ZERO_RST;
            cfg_reg.gap_ticks    <= irpw_pkg::GAP_RST;
            cfg_reg.repeat_count <= irpw_pkg::REPEAT_RST;
            cfg_reg.carrier_div  <= irpw_pkg::CARRIER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline control: the input stage drains whenever the result register is
    // empty or being taken, so a full pipe takes a request every cycle while results are taken.
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign tick          = adv && (in_func_reg == irpw_pkg::FUNC_TICK);
    assign send          = adv && (in_func_reg == irpw_pkg::FUNC_SEND);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_func_reg <= s_axis_tuser;
            in_code_reg <= s_axis_tdata[irpw_pkg::CODE_W-1:0];
        end
        if (adv)
        begin
            out_bits_reg <= {stat.done_next, stat.busy_next, stat.mark_next,
                             stat.mark_next & level_next};
        end
    end

    irpw_carrier u_carrier (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .carrier_div (cfg_reg.carrier_div),
        .level_next  (level_next)
    );

    irpw_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .send  (send),
        .code  (in_code_reg),
        .cfg   (cfg_reg),
        .stat  (stat)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(irpw_pkg::OUT_DATA_W - 4){1'b0}}, out_bits_reg};

    // frames owed exactly while a transmission runs
    a_frames_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.frames_live == !stat.idle)
        else $error("frame count out of step with sequencer phase");

    // a done result leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && stat.done_next |=> stat.idle)
        else $error("sequencer not idle after final frame");

    // a send request taken while idle gives a busy result
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        send && stat.idle |=> out_valid_reg && out_bits_reg[2])
        else $error("send request did not start a transmission");

    // carrier only reaches the LED during a mark
    a_ir_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !stat.mark_next |=> !out_bits_reg[0])
        else $error("LED driven outside a mark");

endmodule

[sim/tb_ir_pulse_width_transmitter.sv]
// Self-checking testbench for the pulse-width IR transmitter: directed frames, random traffic.
`timescale 1ns / 1ps

module tb_ir_pulse_width_transmitter;

    localparam int CYCLE_LIMIT = 400000;
    // index 7 has no register behind it; writes there must change nothing
    localparam logic [irpw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one request: func on tuser, code_word on tdata
    typedef struct packed {
        logic                        func;
        logic [irpw_pkg::CODE_W-1:0] code;
    } request_t;

    // result fields, bit 3 first, laid out as on m_axis_tdata
    typedef struct packed {
        logic done_res;
        logic busy_res;
        logic mark_active;
        logic ir_out;
    } tx_status_t;

    // ------------------------------------------------------------------
    // DUT connections, inputs known from time zero
    // ------------------------------------------------------------------
    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [irpw_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;    // [11:0] code_word, [15:12] zero
    logic                            s_axis_tuser  = 1'b0;  // [0] func
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [irpw_pkg::OUT_DATA_W-1:0] m_axis_tdata;          // [0] ir_out, [1] mark_active,
                                                            // [2] busy_res, [3] done_res
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [irpw_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [irpw_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    ir_pulse_width_transmitter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow registers, mirrored on every config handshake
    // ------------------------------------------------------------------
    logic [irpw_pkg::TICK_W-1:0] hdr_len    = irpw_pkg::HEADER_RST;
    logic [irpw_pkg::TICK_W-1:0] spc_len    = irpw_pkg::SPACE_RST;
    logic [irpw_pkg::TICK_W-1:0] one_len    = irpw_pkg::ONE_RST;
    logic [irpw_pkg::TICK_W-1:0] zero_len   = irpw_pkg::ZERO_RST;
    logic [irpw_pkg::TICK_W-1:0] gap_len    = irpw_pkg::GAP_RST;
    logic [irpw_pkg::REP_W-1:0]  frame_reps = irpw_pkg::REPEAT_RST;
    logic [irpw_pkg::DIV_W-1:0]  car_div    = irpw_pkg::CARRIER_RST;

    // Transmitter state as the predictor sees it, reset values
    irpw_pkg::phase_t                tx_phase    = irpw_pkg::PH_IDLE;
    logic [irpw_pkg::BIT_IDX_W-1:0]  bit_cnt     = '0;
    logic [irpw_pkg::CODE_BITS-1:0]  shift_reg   = '0;
    logic [irpw_pkg::CODE_BITS-1:0]  code_latch  = '0;
    logic [irpw_pkg::TICK_W-1:0]     seg_left    = '0;
    logic [irpw_pkg::DIV_W-1:0]      car_cnt     = '0;
    logic                            car_lvl     = 1'b0;
    logic [irpw_pkg::REP_W-1:0]      frames_owed = '0;

    // stimulus and expectation stores
    request_t   request_q[$];
    tx_status_t status_q[$];

    logic req_fired = 1'b0;    // request handshake seen at the last rising edge
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    int mismatch_cnt  = 0;
    int requests_taken = 0;
    int results_seen  = 0;
    int sends_taken   = 0;
    int frames_ended  = 0;
    int cfg_writes    = 0;
    int cycle_cnt     = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void load_frame();
        shift_reg = code_latch;
        bit_cnt   = '0;
        tx_phase  = irpw_pkg::PH_HEADER;
        seg_left  = hdr_len;
    endfunction

    // mark length picked by the current MSB
    function automatic void load_bit_mark();
        tx_phase = irpw_pkg::PH_BITMARK;
        seg_left = shift_reg[irpw_pkg::CODE_BITS-1] ? one_len : zero_len;
    endfunction

    function automatic tx_status_t step_transmitter(input logic func,
                                                    input logic [irpw_pkg::CODE_W-1:0] code);
        tx_status_t st;
        logic       last_frame;
        last_frame = 1'b0;
        if (func == irpw_pkg::FUNC_SEND)
        begin
            // a send while busy is dropped; no time passes either way
            if (tx_phase == irpw_pkg::PH_IDLE)
            begin
                code_latch  = code[irpw_pkg::CODE_BITS-1:0];
                frames_owed = (frame_reps == '0) ? irpw_pkg::REP_W'(1) : frame_reps;
                sends_taken++;
                load_frame();
            end
        end
        else
        begin
            // carrier free-runs on every tick, idle or not
            if (car_cnt >= car_div)
            begin
                car_cnt = '0;
                car_lvl = ~car_lvl;
            end
            else
            begin
                car_cnt = car_cnt + 1'b1;
            end
            if (tx_phase != irpw_pkg::PH_IDLE)
            begin
                if (seg_left <= 1)
                begin
                    unique case (tx_phase)
                        irpw_pkg::PH_HEADER:
                        begin
                            tx_phase = irpw_pkg::PH_HSPACE;
                            seg_left = spc_len;
                        end
                        irpw_pkg::PH_HSPACE: load_bit_mark();
                        irpw_pkg::PH_BITMARK:
                        begin
                            tx_phase = irpw_pkg::PH_BITSPACE;
                            seg_left = spc_len;
                        end
                        irpw_pkg::PH_BITSPACE:
                        begin
                            shift_reg = shift_reg << 1;
                            bit_cnt   = bit_cnt + 1'b1;
                            if (bit_cnt < irpw_pkg::CODE_BITS)
                            begin
                                load_bit_mark();
                            end
                            else if (frames_owed > 1)
                            begin
                                frames_owed = frames_owed - 1'b1;
                                if (gap_len == '0)
                                begin
                                    load_frame();
                                end
                                else
                                begin
                                    tx_phase = irpw_pkg::PH_GAP;
                                    seg_left = gap_len;
                                end
                            end
                            else
                            begin
                                frames_owed = '0;
                                tx_phase    = irpw_pkg::PH_IDLE;
                                seg_left    = '0;
                                bit_cnt     = '0;
                                last_frame  = 1'b1;
                            end
                        end
                        irpw_pkg::PH_GAP: load_frame();
                        default:
                        begin
                            tx_phase = irpw_pkg::PH_IDLE;
                            seg_left = '0;
                        end
                    endcase
                end
                else
                begin
                    seg_left = seg_left - 1'b1;
                end
            end
        end
        if (last_frame)
            frames_ended++;
        st.mark_active = (tx_phase == irpw_pkg::PH_HEADER) ||
                         (tx_phase == irpw_pkg::PH_BITMARK);
        st.ir_out      = st.mark_active & car_lvl;
        st.busy_res    = (tx_phase != irpw_pkg::PH_IDLE);
        st.done_res    = last_frame;
        return st;
    endfunction

    function automatic void check_field(input string name, input logic want_bit,
                                        input logic got_bit);
        if (got_bit !== want_bit)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, want_bit, got_bit);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge, holds until accepted
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        request_t nxt;
        if (rst_n && (!s_axis_tvalid || req_fired))
        begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.func;
                s_axis_tdata  <= {{(irpw_pkg::IN_DATA_W - irpw_pkg::CODE_W){1'b0}}, nxt.code};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        // result side back-pressure
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: results checked before this edge's request is predicted,
    // so a stray result can never borrow a fresh expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        tx_status_t got;
        tx_status_t want;
        if (!rst_n)
        begin
            req_fired <= 1'b0;
        end
        else
        begin
            req_fired <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[3:0];
                results_seen++;
                if (status_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: result with nothing expected, expected none, got %b",
                             $time, got);
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("ir_out",      want.ir_out,      got.ir_out);
                    check_field("mark_active", want.mark_active, got.mark_active);
                    check_field("busy_res",    want.busy_res,    got.busy_res);
                    check_field("done_res",    want.done_res,    got.done_res);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                status_q.push_back(step_transmitter(s_axis_tuser,
                                                    s_axis_tdata[irpw_pkg::CODE_W-1:0]));
                requests_taken++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, status_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_send(input logic [irpw_pkg::CODE_W-1:0] code);
        request_q.push_back('{func: irpw_pkg::FUNC_SEND, code: code});
    endfunction

    // tick requests carry random don't-care codes
    function automatic void queue_ticks(input int n);
        for (int k = 0; k < n; k++)
            request_q.push_back('{func: irpw_pkg::FUNC_TICK,
                                  code: irpw_pkg::CODE_W'($urandom)});
    endfunction

    // 0: none, 1: sender gaps, 2: receiver stalls, 3: light on both sides
    function automatic void select_idling(input int mode);
        send_idle_pct  = (mode == 1) ? 51 : (mode == 3) ? 9 : 0;
        recv_stall_pct = (mode == 2) ? 51 : (mode == 3) ? 9 : 0;
    endfunction

    task automatic write_reg(input logic [irpw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [irpw_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            irpw_pkg::REG_HEADER:  hdr_len    = data;
            irpw_pkg::REG_SPACE:   spc_len    = data;
            irpw_pkg::REG_ONE:     one_len    = data;
            irpw_pkg::REG_ZERO:    zero_len   = data;
            irpw_pkg::REG_GAP:     gap_len    = data;
            irpw_pkg::REG_REPEAT:  frame_reps = data[irpw_pkg::REP_W-1:0];
            irpw_pkg::REG_CARRIER: car_div    = data[irpw_pkg::DIV_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all requests taken and all results back
    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // tick on until the predicted transmitter is idle again
    task automatic finish_transmission();
        wait_drained();
        while (tx_phase != irpw_pkg::PH_IDLE)
        begin
            queue_ticks(32);
            wait_drained();
        end
    endtask

    task automatic randomise_timing();
        int c;
        write_reg(irpw_pkg::REG_HEADER, irpw_pkg::CFG_DATA_W'($urandom_range(1, 3)));
        write_reg(irpw_pkg::REG_SPACE,  irpw_pkg::CFG_DATA_W'($urandom_range(1, 2)));
        write_reg(irpw_pkg::REG_ONE,    irpw_pkg::CFG_DATA_W'($urandom_range(1, 3)));
        write_reg(irpw_pkg::REG_ZERO,   irpw_pkg::CFG_DATA_W'($urandom_range(1, 2)));
        write_reg(irpw_pkg::REG_GAP,    irpw_pkg::CFG_DATA_W'($urandom_range(0, 4)));
        // repeat mostly short; junk above the field must be dropped
        c = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 7);
        write_reg(irpw_pkg::REG_REPEAT, {17'($urandom), 3'(c)});
        case ($urandom_range(0, 3))
            0:       c = 0;
            1:       c = 255;
            2:       c = $urandom_range(0, 7);
            default: c = $urandom_range(0, 255);
        endcase
        write_reg(irpw_pkg::REG_CARRIER, {12'($urandom), 8'(c)});
    endtask

    // Mostly send + tick run sized around one transmission; short runs
    // leave the block busy so the next send is dropped, and stray sends
    // land inside runs.
    task automatic queue_random_traffic(input int budget);
        int added;
        int est;
        int run;
        int sel;
        added = 0;
        while (added < budget)
        begin
            est = (int'(frame_reps) + 1) * (int'(hdr_len) + int'(spc_len) + 2 +
                  12 * (int'(one_len) + int'(spc_len) + 2) + int'(gap_len));
            sel = $urandom_range(0, 9);
            queue_send((sel == 0) ? {irpw_pkg::CODE_W{1'b0}} :
                       (sel == 1) ? {irpw_pkg::CODE_W{1'b1}} : irpw_pkg::CODE_W'($urandom));
            run = $urandom_range(1, est + est / 4);
            for (int k = 0; k < run; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                    queue_send(irpw_pkg::CODE_W'($urandom));
                else
                    queue_ticks(1);
            end
            added += run + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: carrier alone, long enough for a toggle at the default divider
        select_idling(0);
        queue_ticks($urandom_range(110, 160));
        wait_drained();

        // shortest lengths, back-to-back frames with no gap, fast carrier;
        // second send arrives while busy and must be dropped
        select_idling(1);
        write_reg(irpw_pkg::REG_HEADER,  20'd1);
        write_reg(irpw_pkg::REG_SPACE,   20'd1);
        write_reg(irpw_pkg::REG_ONE,     20'd2);
        write_reg(irpw_pkg::REG_ZERO,    20'd1);
        write_reg(irpw_pkg::REG_GAP,     20'd0);
        write_reg(irpw_pkg::REG_REPEAT,  20'd2);
        write_reg(irpw_pkg::REG_CARRIER, 20'd0);
        write_reg(REG_UNUSED,            20'hFFFFF);
        queue_send(12'hFFF);
        queue_send(12'h123);
        queue_ticks(6);
        finish_transmission();
        queue_send(12'h000);
        finish_transmission();

        // zero-length segments, zero repeat (one frame), slowest carrier
        select_idling(2);
        write_reg(irpw_pkg::REG_HEADER,  20'd0);
        write_reg(irpw_pkg::REG_SPACE,   20'd0);
        write_reg(irpw_pkg::REG_ONE,     20'd0);
        write_reg(irpw_pkg::REG_ZERO,    20'd0);
        write_reg(irpw_pkg::REG_GAP,     20'd0);
        write_reg(irpw_pkg::REG_REPEAT,  {17'h1FFFF, 3'd0});
        write_reg(irpw_pkg::REG_CARRIER, 20'hFFFFF);
        queue_send(12'hA50);
        finish_transmission();
        queue_send(12'h800);
        queue_send(12'hFFF);
        finish_transmission();

        // gaps between frames, maximum repeat
        select_idling(3);
        write_reg(irpw_pkg::REG_HEADER,  20'd2);
        write_reg(irpw_pkg::REG_SPACE,   20'd2);
        write_reg(irpw_pkg::REG_ONE,     20'd3);
        write_reg(irpw_pkg::REG_ZERO,    20'd1);
        write_reg(irpw_pkg::REG_GAP,     20'd3);
        write_reg(irpw_pkg::REG_REPEAT,  20'd7);
        write_reg(irpw_pkg::REG_CARRIER, 20'd1);
        queue_send(irpw_pkg::CODE_W'($urandom));
        queue_ticks(5);
        queue_send(12'h5A5);
        finish_transmission();

        // random timing and traffic, one phase per idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            select_idling(ph);
            randomise_timing();
            queue_random_traffic(40);
            finish_transmission();
        end

        // every register at its top value; block is left mid-header at the end
        select_idling(3);
        write_reg(irpw_pkg::REG_HEADER,  20'hFFFFF);
        write_reg(irpw_pkg::REG_SPACE,   20'hFFFFF);
        write_reg(irpw_pkg::REG_ONE,     20'hFFFFF);
        write_reg(irpw_pkg::REG_ZERO,    20'hFFFFF);
        write_reg(irpw_pkg::REG_GAP,     20'hFFFFF);
        write_reg(irpw_pkg::REG_REPEAT,  20'hFFFFF);
        write_reg(irpw_pkg::REG_CARRIER, 20'hFFFFF);
        queue_send(irpw_pkg::CODE_W'($urandom));
        queue_ticks(20);
        queue_send(irpw_pkg::CODE_W'($urandom));
        queue_ticks(60);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d requests and %0d results over %0d register writes,",
                 requests_taken, results_seen, cfg_writes);
        $display("with %0d sends taken and %0d transmissions run to completion.",
                 sends_taken, frames_ended);
        if (mismatch_cnt == 0 && status_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/core/irpw_pkg.sv
rtl/core/irpw_carrier.sv
rtl/core/irpw_sequencer.sv
rtl/core/ir_pulse_width_transmitter.sv
sim/tb_ir_pulse_width_transmitter.sv
